// ===== sv/akc_pkg.sv =====
// ---------------------------------------------------------------------------
// akc_pkg: shared types, constants and helpers of the autokey cipher stream
// Letter decoding, mod-26 arithmetic and the ring write bundle.
// ---------------------------------------------------------------------------
package akc_pkg;

  localparam int MAX_KEY_LEN_DEF = 12;
  localparam int ALPHABET_SIZE   = 26;
  localparam int KEY_SLOTS       = 12;
  localparam int CODE_W          = 5;
  localparam int CNT_W           = 4;
  localparam int SLOT_W          = 4;
  localparam int CHAR_W          = 8;
  localparam int LETTER_W        = 7;
  localparam int KEYWORD_W       = KEY_SLOTS * CODE_W;
  localparam int CFG_W           = KEYWORD_W;

  localparam logic [CHAR_W-1:0]   UPPER_A  = 8'd65;
  localparam logic [CHAR_W-1:0]   UPPER_Z  = 8'd90;
  localparam logic [CHAR_W-1:0]   LOWER_A  = 8'd97;
  localparam logic [CHAR_W-1:0]   LOWER_Z  = 8'd122;
  localparam logic [LETTER_W-1:0] ASCII_A  = 7'd65;
  localparam logic [CODE_W:0]     ALPHA_6  = 6'd26;

  typedef enum logic [1:0] {
    CFG_MODE        = 2'd0,
    CFG_KEY_LEN     = 2'd1,
    CFG_KEY_LETTERS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic              is_letter;
    logic [CODE_W-1:0] code;
  } letter_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [CODE_W-1:0] data;
  } ring_wr_t;

  // Folds A-Z and a-z to codes 0..25; anything else is flagged as a non-letter.
  function automatic letter_t decode_char(input logic [CHAR_W-1:0] ch);
    letter_t             r;
    logic [CHAR_W-1:0]   d;
    r = '0;
    d = '0;
    if (ch >= UPPER_A && ch <= UPPER_Z) begin
      d = ch - UPPER_A;
      r.is_letter = 1'b1;
      r.code = d[CODE_W-1:0];
    end else if (ch >= LOWER_A && ch <= LOWER_Z) begin
      d = ch - LOWER_A;
      r.is_letter = 1'b1;
      r.code = d[CODE_W-1:0];
    end
    return r;
  endfunction

  // Reduces a value below 52 into 0..25 with one compare and subtract.
  function automatic logic [CODE_W-1:0] reduce26(input logic [CODE_W:0] v);
    logic [CODE_W:0] s;
    s = (v >= ALPHA_6) ? (v - ALPHA_6) : v;
    return s[CODE_W-1:0];
  endfunction

  function automatic logic [CODE_W-1:0] add26(input logic [CODE_W-1:0] a,
                                              input logic [CODE_W-1:0] b);
    return reduce26({1'b0, a} + {1'b0, b});
  endfunction

  // a - b mod 26, with both operands already in 0..25.
  function automatic logic [CODE_W-1:0] sub26(input logic [CODE_W-1:0] a,
                                              input logic [CODE_W-1:0] b);
    return reduce26({1'b0, a} + ALPHA_6 - {1'b0, b});
  endfunction

endpackage

// ===== sv/autokey_cipher_stream.sv =====
// ---------------------------------------------------------------------------
// autokey_cipher_stream: autokey (Vigenere family) cipher over a byte stream
// Encrypts or decrypts one character per beat with a keyword-primed keystream.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, in_char, in_msg_start) takes one raw
// byte per beat. Letters of either case are folded to upper case; any other
// byte is consumed but produces no output beat and leaves the keystream alone.
// Setting in_msg_start on a beat restarts the keystream at the keyword before
// that byte is handled, even when the byte itself is not a letter.
// The output channel (out_valid, out_stall, out_letter) carries one upper-case
// ASCII letter per input letter, in order.
// An accepted letter passes the compute stage, then the output register. The
// block takes one beat every cycle while in_stall is low; each letter does one
// ring read, a mod-26 add or subtract and a ring write, with the read issued at
// acceptance and the write as the letter leaves the compute stage, so a letter
// that reads the slot its predecessor is writing gets the value forwarded. An
// output register decouples the channels: a new beat is still taken while a
// result waits, and in_stall rises only once both the compute stage and the
// output register are full behind a stalled receiver. Reset (rst_n low at a
// clock edge) clears the keystream position, the configuration registers and
// the pipeline; the ring needs no clearing pass. Configuration (cfg_we, cfg_idx,
// cfg_wdata) must be written only while idle; the block does not enforce it.
// ---------------------------------------------------------------------------
module autokey_cipher_stream #(
  parameter int MAX_KEY_LEN = akc_pkg::MAX_KEY_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write port
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_idx,
  input  logic [akc_pkg::CFG_W-1:0]     cfg_wdata,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [akc_pkg::CHAR_W-1:0]    in_char,
  input  logic                          in_msg_start,
  // Output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [akc_pkg::LETTER_W-1:0]  out_letter
);

  localparam int CODE_W = akc_pkg::CODE_W;
  localparam int CNT_W  = akc_pkg::CNT_W;
  localparam int SLOT_W = akc_pkg::SLOT_W;
  localparam int ADDR_W = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_KEY_LEN);

  // Configuration registers.
  logic                          mode_r;
  logic [CNT_W-1:0]              key_len_r;
  logic [akc_pkg::KEYWORD_W-1:0] keyword_r;

  // Keystream position.
  logic [CNT_W-1:0]  letter_cnt_r, letter_cnt_nxt;
  logic [SLOT_W-1:0] ring_pos_r, ring_pos_nxt;

  // Compute stage: the ring read for this letter lands here.
  logic              s1_valid_r, s1_valid_nxt;
  logic [CODE_W-1:0] s1_code_r;
  logic              s1_use_kw_r;
  logic [CODE_W-1:0] s1_kw_code_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic              s1_fwd_r;
  logic [CODE_W-1:0] s1_fwd_data_r;

  // Output register.
  logic                         out_valid_r, out_valid_nxt;
  logic [akc_pkg::LETTER_W-1:0] out_letter_r;

  logic                 in_accept;
  logic                 s1_adv;
  akc_pkg::letter_t     dec;
  logic [CNT_W-1:0]     eff_len;
  logic [CNT_W-1:0]     lc_eff;
  logic [SLOT_W-1:0]    pos_eff;
  logic [SLOT_W-1:0]    slot;
  logic [SLOT_W:0]      slot_inc;
  logic                 use_kw;
  logic [CODE_W-1:0]    kw_arr [akc_pkg::KEY_SLOTS];
  logic [CODE_W-1:0]    kw_code;
  logic [CODE_W-1:0]    ring_rd_data;
  logic [CODE_W-1:0]    ring_key;
  logic [CODE_W-1:0]    key;
  logic [CODE_W-1:0]    res;
  logic [CODE_W-1:0]    plain;
  akc_pkg::ring_wr_t    ring_wr;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      key_len_r <= CNT_W'(1);
      keyword_r <= '0;
    end else if (cfg_we) begin
      case (akc_pkg::cfg_idx_t'(cfg_idx))
        akc_pkg::CFG_MODE:        mode_r    <= cfg_wdata[0];
        akc_pkg::CFG_KEY_LEN:     key_len_r <= cfg_wdata[CNT_W-1:0];
        akc_pkg::CFG_KEY_LETTERS: keyword_r <= cfg_wdata[akc_pkg::KEYWORD_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero length acts as one and anything above the ring depth is clamped.
  always_comb begin
    eff_len = key_len_r;
    if (eff_len == '0) begin
      eff_len = CNT_W'(1);
    end
    if (eff_len > MAX_LEN) begin
      eff_len = MAX_LEN;
    end
  end

  // Keyword codes above 25 are reduced into the alphabet.
  always_comb begin
    for (int i = 0; i < akc_pkg::KEY_SLOTS; i++) begin
      kw_arr[i] = akc_pkg::reduce26({1'b0, keyword_r[i*CODE_W +: CODE_W]});
    end
  end

  // The compute stage drains into the output register when that is free or
  // being emptied; a new beat is taken whenever the compute stage can move.
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // Stage 0: decode, pick the ring slot and the keyword letter, issue the read.
  always_comb begin
    dec     = akc_pkg::decode_char(in_char);
    lc_eff  = in_msg_start ? '0 : letter_cnt_r;
    pos_eff = in_msg_start ? '0 : ring_pos_r;
    // A slot past the length only follows a length change within a message.
    slot    = ({1'b0, pos_eff} >= {1'b0, eff_len}) ? '0 : pos_eff;
    use_kw  = lc_eff < eff_len;
    kw_code = kw_arr[lc_eff];
    slot_inc = {1'b0, slot} + (SLOT_W+1)'(1);

    letter_cnt_nxt = letter_cnt_r;
    ring_pos_nxt   = ring_pos_r;
    if (in_accept) begin
      letter_cnt_nxt = lc_eff;
      ring_pos_nxt   = pos_eff;
      if (dec.is_letter) begin
        ring_pos_nxt = (slot_inc >= {1'b0, eff_len}) ? '0 : slot_inc[SLOT_W-1:0];
        if (use_kw) begin
          letter_cnt_nxt = lc_eff + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      letter_cnt_r <= '0;
      ring_pos_r   <= '0;
    end else begin
      letter_cnt_r <= letter_cnt_nxt;
      ring_pos_r   <= ring_pos_nxt;
    end
  end

  // Stage 1: pick the key, apply the cipher and write the plaintext back.
  always_comb begin
    ring_key = s1_fwd_r ? s1_fwd_data_r : ring_rd_data;
    key      = s1_use_kw_r ? s1_kw_code_r : ring_key;
    if (mode_r) begin
      res   = akc_pkg::sub26(s1_code_r, key);
      plain = res;
    end else begin
      res   = akc_pkg::add26(s1_code_r, key);
      plain = s1_code_r;
    end
    ring_wr.en   = s1_adv;
    ring_wr.addr = s1_slot_r;
    ring_wr.data = plain;
  end

  akc_ring #(
    .DEPTH  (MAX_KEY_LEN),
    .ADDR_W (ADDR_W)
  ) u_ring (
    .clk       (clk),
    .wr        (ring_wr),
    .rd_en     (in_accept),
    .rd_addr   (slot),
    .rd_data_r (ring_rd_data)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = dec.is_letter;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The memory returns the old entry when it is read and written at the same
  // edge, so the plaintext being written is captured for the next letter.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_code_r     <= dec.code;
      s1_use_kw_r   <= use_kw;
      s1_kw_code_r  <= kw_code;
      s1_slot_r     <= slot;
      s1_fwd_r      <= ring_wr.en && (ring_wr.addr == slot);
      s1_fwd_data_r <= plain;
    end
    if (s1_adv) begin
      out_letter_r <= akc_pkg::ASCII_A + akc_pkg::LETTER_W'(res);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_letter = out_letter_r;

`ifndef SYNTHESIS
  // The ring is only ever written inside the configured depth.
  a_ring_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ring_wr.en |-> (ring_wr.addr < SLOT_W'(MAX_KEY_LEN)))
    else $error("ring write outside the ring depth");

  // Input is only held back while both pipeline slots are occupied.
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with a free pipeline slot");

  // A letter leaving the compute stage shows up on the output next cycle.
  a_adv_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced letter lost before the output register");

  // The letter count saturates at the effective key length, never past the ring depth.
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    letter_cnt_r <= MAX_LEN)
    else $error("letter count past the maximum keyword length");
`endif

endmodule

// ===== sv/akc_ring.sv =====
// ---------------------------------------------------------------------------
// akc_ring: plaintext ring memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module akc_ring #(
  parameter int DEPTH  = akc_pkg::MAX_KEY_LEN_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  akc_pkg::ring_wr_t           wr,
  input  logic                        rd_en,
  input  logic [akc_pkg::SLOT_W-1:0]  rd_addr,
  output logic [akc_pkg::CODE_W-1:0]  rd_data_r
);

  logic [akc_pkg::CODE_W-1:0] mem [DEPTH];

  // Contents are undefined until written; the cipher never relies on them.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[ADDR_W-1:0]] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr[ADDR_W-1:0]];
    end
  end

endmodule

// ===== test/autokey_cipher_stream_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// autokey_cipher_stream_tb: self-checking bench for the autokey cipher stream
// Drives character beats with bursty spacing against a randomly stalling
// receiver, predicts every output letter and compares it in order.
// ---------------------------------------------------------------------------
module autokey_cipher_stream_tb;
  import akc_pkg::*;

  // The receiver switches between a few stall habits, one per stretch.
  typedef enum int {
    RX_FREE,
    RX_RANDOM,
    RX_BURSTY
  } rx_habit_t;

  localparam int RANDOM_BEATS = 1400;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [1:0]           cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [CHAR_W-1:0]    in_char;
  logic                 in_msg_start;
  logic                 out_valid;
  logic                 out_stall;
  logic [LETTER_W-1:0]  out_letter;

  // Shadow copy of the configuration registers, updated as they are written.
  logic                 cfg_decrypt;
  logic [CNT_W-1:0]     cfg_key_len;
  logic [KEYWORD_W-1:0] cfg_keyword;

  // Shadow keystream state: letters taken in the message, the next ring slot
  // and the plaintext history that feeds the key once the keyword runs out.
  logic [CNT_W-1:0]     ks_count;
  logic [SLOT_W-1:0]    ks_slot;
  logic [CODE_W-1:0]    plain_hist [KEY_SLOTS];

  // Output letters predicted but not yet seen on the output channel.
  logic [LETTER_W-1:0]  expected_letters [$];

  int error_count;
  int beats_sent;
  int letters_sent;
  int letters_checked;
  int reg_writes;
  int phases_run;
  int burst_left;
  bit steady_stretch;

  autokey_cipher_stream u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char      (in_char),
    .in_msg_start (in_msg_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_letter   (out_letter)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every mismatch goes through here so that the final verdict sees it.
  task automatic flag_mismatch(input string what);
    error_count++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Computes the output of one accepted beat and advances the shadow
  // keystream. A restart takes effect even when the byte is not a letter.
  function automatic void cipher_beat(input logic [CHAR_W-1:0] ch, input logic start,
                                      output logic produces,
                                      output logic [LETTER_W-1:0] letter);
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] key;
    logic [CODE_W-1:0] plain;
    logic [CODE_W-1:0] res;
    logic [CNT_W-1:0]  len;
    logic [SLOT_W-1:0] slot;
    produces = 1'b0;
    letter = '0;
    code = '0;
    if (start) begin
      ks_count = '0;
      ks_slot = '0;
    end
    if (ch >= UPPER_A && ch <= UPPER_Z) begin
      code = CODE_W'(ch - UPPER_A);
      produces = 1'b1;
    end else if (ch >= LOWER_A && ch <= LOWER_Z) begin
      code = CODE_W'(ch - LOWER_A);
      produces = 1'b1;
    end
    if (produces) begin
      // A length of zero acts as one and anything past the ring as its size.
      len = cfg_key_len;
      if (len == '0) len = CNT_W'(1);
      if (len > MAX_KEY_LEN_DEF) len = CNT_W'(MAX_KEY_LEN_DEF);
      // The slot can sit beyond the length after the length shrank mid-message.
      slot = (ks_slot >= len) ? '0 : ks_slot;
      if (ks_count < len)
        key = CODE_W'(int'(cfg_keyword[ks_count*CODE_W +: CODE_W]) % ALPHABET_SIZE);
      else
        key = plain_hist[slot];
      if (!cfg_decrypt) begin
        plain = code;
        res = CODE_W'((int'(key) + int'(code)) % ALPHABET_SIZE);
      end else begin
        plain = CODE_W'((int'(code) + ALPHABET_SIZE - int'(key)) % ALPHABET_SIZE);
        res = plain;
      end
      plain_hist[slot] = plain;
      slot = slot + SLOT_W'(1);
      ks_slot = (slot >= len) ? '0 : slot;
      if (ks_count < len) ks_count = ks_count + CNT_W'(1);
      letter = ASCII_A + LETTER_W'(res);
    end
  endfunction

  // One register write; the enable drops on the following falling edge, so a
  // second write right after it lands on a later edge.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODE:        cfg_decrypt = data[0];
      CFG_KEY_LEN:     cfg_key_len = data[CNT_W-1:0];
      CFG_KEY_LETTERS: cfg_keyword = data[KEYWORD_W-1:0];
      default:         ;
    endcase
    reg_writes++;
  endtask

  // Sends one character beat. Beats go out in bursts of random length with
  // random gaps in between, except during a steady stretch. Valid stays high
  // from one beat to the next inside a burst.
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic start);
    logic                produces;
    logic [LETTER_W-1:0] letter;
    int                  gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0 || steady_stretch) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
        in_char <= CHAR_W'($urandom_range(0, 255));
        in_msg_start <= 1'($urandom_range(0, 1));
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_char <= ch;
    in_msg_start <= start;
    do @(posedge clk); while (in_stall);
    cipher_beat(ch, start, produces, letter);
    if (produces) begin
      expected_letters.push_back(letter);
      letters_sent++;
    end
    beats_sent++;
  endtask

  // Stops sending and waits for every predicted letter, then lets the two
  // pipeline stages empty in case the last beats were non-letters.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_letters.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic logic [CHAR_W-1:0] any_letter();
    logic [CHAR_W-1:0] base;
    base = $urandom_range(0, 1) ? UPPER_A : LOWER_A;
    return base + CHAR_W'($urandom_range(0, 25));
  endfunction

  function automatic logic [CNT_W-1:0] pick_key_len();
    case ($urandom_range(0, 5))
      0:       return 4'd0;
      1:       return 4'd1;
      2:       return 4'd12;
      3:       return 4'd15;
      default: return CNT_W'($urandom_range(0, 15));
    endcase
  endfunction

  // All-ones puts every code at 31, well past the alphabet.
  function automatic logic [CFG_W-1:0] pick_keyword();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return raw[CFG_W-1:0];
    endcase
  endfunction

  // Sends the characters of a string, restarting the keystream on the first.
  task automatic send_text(input string text, input logic restart);
    for (int i = 0; i < text.len(); i++)
      send_char(text[i], restart && i == 0);
  endtask

  // The first message uses the longest keyword so that every ring slot is
  // written before anything can read it; later messages reuse those slots.
  // The keyword holds codes above 25 to check the reduction.
  task automatic test_fill_ring();
    logic [CFG_W-1:0] kw;
    for (int i = 0; i < KEY_SLOTS; i++)
      kw[i*CODE_W +: CODE_W] = CODE_W'((i * 7 + 3) % 32);
    write_reg(CFG_MODE, '0);
    write_reg(CFG_KEY_LEN, CFG_W'(12));
    write_reg(CFG_KEY_LETTERS, kw);
    send_text("AZazMqbYcXnWK", 1'b1);
  endtask

  // Bytes just outside both letter ranges, the byte extremes, and a restart
  // carried by a space, after which the next letter takes the first key.
  task automatic test_non_letters();
    send_text("@[{", 1'b0);
    send_char(8'h60, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(" ", 1'b1);
    send_char("E", 1'b0);
  endtask

  // Decryption with the length register at zero, which acts as one, so the
  // second letter already keys off the recovered plaintext.
  task automatic test_decrypt_short_key();
    wait_idle();
    write_reg(CFG_MODE, CFG_W'(1));
    write_reg(CFG_KEY_LEN, '0);
    send_text("Qhr", 1'b1);
  endtask

  // Length changes inside a message: growing past the letter count brings the
  // keyword back, and shrinking below the ring position wraps it to slot zero.
  task automatic test_length_change();
    wait_idle();
    write_reg(CFG_KEY_LEN, CFG_W'(15));
    send_text("bC", 1'b0);
    wait_idle();
    write_reg(CFG_KEY_LEN, CFG_W'(2));
    write_reg(CFG_KEY_LETTERS, '1);
    send_char("T", 1'b0);
  endtask

  // Random messages: mostly letters in either case with a sprinkle of
  // arbitrary bytes and the odd restart in the middle. Each phase begins once
  // everything is out, with a fresh random setting of some registers; some
  // messages carry on from the previous phase without a restart.
  task automatic test_random_traffic();
    int               msg_len;
    logic             fresh;
    logic [CHAR_W-1:0] ch;
    while (beats_sent < RANDOM_BEATS) begin
      wait_idle();
      phases_run++;
      steady_stretch = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) write_reg(CFG_MODE, CFG_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) write_reg(CFG_KEY_LEN, CFG_W'(pick_key_len()));
      if ($urandom_range(0, 1)) write_reg(CFG_KEY_LETTERS, pick_keyword());
      repeat ($urandom_range(1, 4)) begin
        msg_len = $urandom_range(1, 40);
        fresh = ($urandom_range(0, 7) != 0);
        for (int i = 0; i < msg_len; i++) begin
          ch = ($urandom_range(0, 9) == 0) ? CHAR_W'($urandom_range(0, 255)) : any_letter();
          send_char(ch, (fresh && i == 0) || $urandom_range(0, 49) == 0);
        end
      end
    end
  endtask

  // Each output beat is taken at a rising edge with valid high and stall low
  // and must match the oldest predicted letter.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_letters.size() == 0) begin
        flag_mismatch($sformatf("output beat 0x%02h with no letter pending", out_letter));
      end else begin
        if (out_letter !== expected_letters[0])
          flag_mismatch($sformatf("letter %0d: got 0x%02h, want 0x%02h",
                                  letters_checked, out_letter, expected_letters[0]));
        void'(expected_letters.pop_front());
        letters_checked++;
      end
    end
  end

  // Receiver stall pattern: stretches of no stall, scattered random stalls
  // and on/off runs of random length.
  initial begin
    rx_habit_t habit;
    int        hold;
    bit        level;
    hold = 0;
    level = 1'b0;
    out_stall = 1'b0;
    forever begin
      habit = rx_habit_t'($urandom_range(0, 2));
      repeat ($urandom_range(16, 96)) begin
        @(negedge clk);
        case (habit)
          RX_FREE:   out_stall <= 1'b0;
          RX_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
          default: begin
            if (hold == 0) begin
              level = ~level;
              hold = $urandom_range(1, 8);
            end
            hold--;
            out_stall <= level;
          end
        endcase
      end
    end
  end

  // Generous upper bound on the whole run; a hang lands here.
  initial begin
    #3000000;
    $display("Timeout with %0d letters still pending.", expected_letters.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_MODE;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_char = '0;
    in_msg_start = 1'b0;
    cfg_decrypt = 1'b0;
    cfg_key_len = 4'd1;
    cfg_keyword = '0;
    ks_count = '0;
    ks_slot = '0;
    foreach (plain_hist[i]) plain_hist[i] = '0;
    error_count = 0;
    beats_sent = 0;
    letters_sent = 0;
    letters_checked = 0;
    reg_writes = 0;
    phases_run = 0;
    burst_left = 0;
    steady_stretch = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_fill_ring();
    test_non_letters();
    test_decrypt_short_key();
    test_length_change();
    test_random_traffic();

    wait_idle();
    if (expected_letters.size() != 0)
      flag_mismatch($sformatf("%0d letters never arrived", expected_letters.size()));

    $display("Covered %0d character beats and %0d checked letters over %0d random phases,",
             beats_sent, letters_checked, phases_run);
    $display("with %0d register writes across both modes and all key lengths.", reg_writes);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/akc_pkg.sv
sv/akc_ring.sv
sv/autokey_cipher_stream.sv
test/autokey_cipher_stream_tb.sv
